// ===== rtl/core/bva_pkg.sv =====
// Shared types, constants and register codes of the battery voltage averager.
// No dependencies; every other file of the block imports this package.
`timescale 1ns / 1ps
`default_nettype none

package bva_pkg;

  localparam int SAMPLE_W  = 16;
  localparam int PCT_W     = 7;
  // Ring depth must be a power of two: the mean is taken with a shift.
  localparam int RING_DEPTH = 8;
  localparam int RING_AW    = $clog2(RING_DEPTH);
  localparam int TOTAL_W    = SAMPLE_W + RING_AW;

  localparam int PROD_W = 2 * SAMPLE_W;
  localparam int NUM_W  = 3 * SAMPLE_W;
  localparam int PNUM_W = SAMPLE_W + 7;

  // Quotient bits produced by the divider for each of its two uses.
  localparam int CONV_QBITS = SAMPLE_W;
  localparam int PCT_QBITS  = PCT_W;
  localparam int CNT_W      = $clog2(CONV_QBITS + 1);

  localparam logic [SAMPLE_W-1:0] SAMPLE_MAX = '1;
  localparam logic [PCT_W-1:0]    PCT_FULL   = 7'd100;
  localparam logic [PCT_W-1:0]    PCT_EMPTY  = 7'd0;

  // Configuration register indexes.
  localparam int CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] CFG_NUMERATOR   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DENOMINATOR = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_CODE_MAX    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_DROP    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_EMPTY_MV    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_FULL_MV     = 3'd5;

  typedef struct packed {
    logic [SAMPLE_W-1:0] numerator;
    logic [SAMPLE_W-1:0] denominator;
    logic [SAMPLE_W-1:0] code_max;
    logic [SAMPLE_W-1:0] max_drop;
    logic [SAMPLE_W-1:0] empty_mv;
    logic [SAMPLE_W-1:0] full_mv;
  } cfg_t;

  typedef struct packed {
    logic capture;
    logic mul1;
    logic mul2;
    logic conv_start;
    logic conv_take;
    logic update;
    logic pct_start;
    logic pct_take;
    logic out_load;
  } dp_cmd_t;

  typedef struct packed {
    logic good;
    logic sat;
    logic pct_direct;
    logic div_busy;
    logic out_free;
  } dp_stat_t;

endpackage

`default_nettype wire

// ===== rtl/core/bva_cfg.sv =====
// Configuration register file of the battery voltage averager.
// Depends on bva_pkg for the register codes and the cfg_t bundle.
`timescale 1ns / 1ps
`default_nettype none

module bva_cfg
  import bva_pkg::*;
(
  input  wire                  clk,
  input  wire                  rst_n,
  input  wire                  cfg_valid,
  output logic                 cfg_ready,
  input  wire [CFG_IDX_W-1:0]  cfg_index,
  input  wire [SAMPLE_W-1:0]   cfg_data,
  output cfg_t                 cfg
);

  cfg_t cfg_r, cfg_nxt;

  assign cfg_ready = 1'b1;
  assign cfg       = cfg_r;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid) begin
      unique case (cfg_index)
        CFG_NUMERATOR:   cfg_nxt.numerator   = cfg_data;
        CFG_DENOMINATOR: cfg_nxt.denominator = cfg_data;
        CFG_CODE_MAX:    cfg_nxt.code_max    = cfg_data;
        CFG_MAX_DROP:    cfg_nxt.max_drop    = cfg_data;
        CFG_EMPTY_MV:    cfg_nxt.empty_mv    = cfg_data;
        CFG_FULL_MV:     cfg_nxt.full_mv     = cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.numerator   <= 16'd2;
      cfg_r.denominator <= 16'd1;
      cfg_r.code_max    <= 16'd4095;
      cfg_r.max_drop    <= 16'd50;
      cfg_r.empty_mv    <= 16'd3350;
      cfg_r.full_mv     <= 16'd4100;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/bva_div.sv =====
// Restoring divider producing one quotient bit per cycle.
// Depends on bva_pkg for widths; the caller supplies the starting remainder.
`timescale 1ns / 1ps
`default_nettype none

module bva_div
  import bva_pkg::*;
(
  input  wire                  clk,
  input  wire                  rst_n,
  input  wire                  load,
  input  wire [PROD_W-1:0]     rem_init,
  input  wire [SAMPLE_W-1:0]   dvd_lo,
  input  wire [PROD_W-1:0]     divisor,
  input  wire [CNT_W-1:0]      nbits,
  output logic                 busy,
  output logic [SAMPLE_W-1:0]  quot
);

  logic [CNT_W-1:0]    cnt_r;
  logic [PROD_W-1:0]   rem_r;
  logic [SAMPLE_W-1:0] dvd_r;
  logic [SAMPLE_W-1:0] quot_r;
  logic [PROD_W-1:0]   dsr_r;
  logic [PROD_W:0]     trial;
  logic                fits;

  // The starting remainder is below the divisor, so each trial fits in one extra bit.
  assign trial = {rem_r, dvd_r[SAMPLE_W-1]};
  assign fits  = trial >= {1'b0, dsr_r};
  assign busy  = cnt_r != '0;
  assign quot  = quot_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (load) begin
      cnt_r <= nbits;
    end else if (busy) begin
      cnt_r <= cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      rem_r  <= rem_init;
      dvd_r  <= dvd_lo;
      dsr_r  <= divisor;
      quot_r <= '0;
    end else if (busy) begin
      rem_r  <= fits ? PROD_W'(trial - {1'b0, dsr_r}) : PROD_W'(trial);
      dvd_r  <= {dvd_r[SAMPLE_W-2:0], 1'b0};
      quot_r <= {quot_r[SAMPLE_W-2:0], fits};
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/bva_ctrl.sv =====
// Sequencing state machine of the battery voltage averager.
// Depends on bva_pkg for the datapath command and status bundles.
`timescale 1ns / 1ps
`default_nettype none

module bva_ctrl
  import bva_pkg::*;
(
  input  wire       clk,
  input  wire       rst_n,
  input  wire       in_valid,
  output logic      in_ready,
  input  wire dp_stat_t st,
  output dp_cmd_t   cmd
);

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_MUL1 = 4'd1;
  localparam logic [3:0] S_MUL2 = 4'd2;
  localparam logic [3:0] S_SAT  = 4'd3;
  localparam logic [3:0] S_DIV1 = 4'd4;
  localparam logic [3:0] S_UPD  = 4'd5;
  localparam logic [3:0] S_PCT  = 4'd6;
  localparam logic [3:0] S_DIV2 = 4'd7;
  localparam logic [3:0] S_DONE = 4'd8;

  logic [3:0] state_r, state_nxt;

  assign in_ready = state_r == S_IDLE;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_nxt   = S_MUL1;
        end
      end
      S_MUL1: begin
        cmd.mul1  = 1'b1;
        state_nxt = S_MUL2;
      end
      S_MUL2: begin
        cmd.mul2  = 1'b1;
        state_nxt = S_SAT;
      end
      S_SAT: begin
        if (!st.good) begin
          state_nxt = S_UPD;
        end else begin
          cmd.conv_start = 1'b1;
          state_nxt      = st.sat ? S_UPD : S_DIV1;
        end
      end
      S_DIV1: begin
        if (!st.div_busy) begin
          cmd.conv_take = 1'b1;
          state_nxt     = S_UPD;
        end
      end
      S_UPD: begin
        cmd.update = 1'b1;
        state_nxt  = S_PCT;
      end
      S_PCT: begin
        cmd.pct_start = 1'b1;
        state_nxt     = st.pct_direct ? S_DONE : S_DIV2;
      end
      S_DIV2: begin
        if (!st.div_busy) begin
          cmd.pct_take = 1'b1;
          state_nxt    = S_DONE;
        end
      end
      S_DONE: begin
        if (st.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> state_r == S_MUL1)
    else $error("accepted item did not start the multiply step");

  a_div_waits: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DIV1 && st.div_busy) |=> (state_r == S_DIV1))
    else $error("controller left the conversion divide early");

  a_state_legal: assert property (@(posedge clk) disable iff (!rst_n)
    state_r <= S_DONE)
    else $error("controller reached an unused state code");

endmodule

`default_nettype wire

// ===== rtl/core/bva_dp.sv =====
// Datapath: input capture, multipliers, shared divider, sample ring and output register.
// Depends on bva_pkg and instantiates bva_div.
`timescale 1ns / 1ps
`default_nettype none

module bva_dp
  import bva_pkg::*;
(
  input  wire                  clk,
  input  wire                  rst_n,
  input  wire dp_cmd_t         cmd,
  output dp_stat_t             st,
  input  wire cfg_t            cfg,
  input  wire [SAMPLE_W-1:0]   in_battery_code,
  input  wire [SAMPLE_W-1:0]   in_supply_mv,
  input  wire                  in_conversion_good,
  input  wire                  in_limit_drop,
  input  wire                  in_purge_ring,
  output logic                 out_valid,
  input  wire                  out_ready,
  output logic [SAMPLE_W-1:0]  out_sample_mv,
  output logic                 out_sample_stored,
  output logic [SAMPLE_W-1:0]  out_average_mv,
  output logic [PCT_W-1:0]     out_charge_percent
);

  // Captured item.
  logic [SAMPLE_W-1:0] code_r, vdda_r;
  logic                good_r, limit_r, purge_r;

  // Conversion arithmetic.
  logic [PROD_W-1:0]   prod_r, den_r;
  logic [NUM_W-1:0]    num_r;
  logic [SAMPLE_W-1:0] sample_r;

  // Ring state.
  logic [SAMPLE_W-1:0] ring_r [RING_DEPTH];
  logic [RING_AW-1:0]  idx_r;
  logic [SAMPLE_W-1:0] last_r;
  logic [TOTAL_W-1:0]  total_r;

  // Result registers.
  logic [SAMPLE_W-1:0] avg_r;
  logic [PCT_W-1:0]    pct_r;
  logic                out_valid_r;
  logic [SAMPLE_W-1:0] out_sample_mv_r, out_average_mv_r;
  logic                out_sample_stored_r;
  logic [PCT_W-1:0]    out_charge_percent_r;

  // Divider hookup.
  logic                div_load, div_busy;
  logic [PROD_W-1:0]   div_rem, div_dsr;
  logic [SAMPLE_W-1:0] div_lo, div_quot;
  logic [CNT_W-1:0]    div_nbits;

  logic                sat_c;
  logic [SAMPLE_W-1:0] floor_c, limited_c, new_last_c, avg_c;
  logic                pct_hi_c, pct_lo_c;
  logic [PNUM_W-1:0]   pnum_c;
  logic [SAMPLE_W-1:0] span_c;

  // The quotient exceeds the sample range exactly when num / 2^16 >= den.
  // A zero divisor lands here as well and saturates.
  assign sat_c = num_r[NUM_W-1:SAMPLE_W] >= den_r;

  always_comb begin
    floor_c   = last_r - cfg.max_drop;
    limited_c = sample_r;
    if (limit_r && (last_r >= cfg.max_drop) && (sample_r < floor_c)) begin
      limited_c = floor_c;
    end
    new_last_c = good_r ? limited_c : last_r;
  end

  assign avg_c    = SAMPLE_W'(total_r >> RING_AW);
  assign pct_hi_c = avg_c >= cfg.full_mv;
  assign pct_lo_c = avg_c <= cfg.empty_mv;
  assign span_c   = cfg.full_mv - cfg.empty_mv;
  assign pnum_c   = PNUM_W'(avg_c - cfg.empty_mv) * PNUM_W'(PCT_FULL);

  // The percentage quotient stays below 2^7, so its high part starts as the remainder.
  always_comb begin
    div_load  = 1'b0;
    div_rem   = num_r[NUM_W-1:SAMPLE_W];
    div_lo    = num_r[SAMPLE_W-1:0];
    div_dsr   = den_r;
    div_nbits = CNT_W'(CONV_QBITS);
    if (cmd.conv_start && !sat_c) begin
      div_load = 1'b1;
    end else if (cmd.pct_start && !(pct_hi_c || pct_lo_c)) begin
      div_load  = 1'b1;
      div_rem   = PROD_W'(pnum_c[PNUM_W-1:PCT_QBITS]);
      div_lo    = {pnum_c[PCT_QBITS-1:0], (SAMPLE_W - PCT_QBITS)'(0)};
      div_dsr   = PROD_W'(span_c);
      div_nbits = CNT_W'(PCT_QBITS);
    end
  end

  bva_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .load     (div_load),
    .rem_init (div_rem),
    .dvd_lo   (div_lo),
    .divisor  (div_dsr),
    .nbits    (div_nbits),
    .busy     (div_busy),
    .quot     (div_quot)
  );

  always_comb begin
    st.good       = good_r;
    st.sat        = sat_c;
    st.pct_direct = pct_hi_c || pct_lo_c;
    st.div_busy   = div_busy;
    st.out_free   = !out_valid_r || out_ready;
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      code_r  <= in_battery_code;
      vdda_r  <= in_supply_mv;
      good_r  <= in_conversion_good;
      limit_r <= in_limit_drop;
      purge_r <= in_purge_ring;
    end
    if (cmd.mul1) begin
      prod_r <= PROD_W'(code_r) * PROD_W'(vdda_r);
      den_r  <= PROD_W'(cfg.code_max) * PROD_W'(cfg.denominator);
    end
    if (cmd.mul2) begin
      num_r <= NUM_W'(prod_r) * NUM_W'(cfg.numerator);
    end
    if (cmd.conv_start && sat_c) begin
      sample_r <= SAMPLE_MAX;
    end
    if (cmd.conv_take) begin
      sample_r <= div_quot;
    end
    if (cmd.pct_start) begin
      avg_r <= avg_c;
      pct_r <= pct_hi_c ? PCT_FULL : PCT_EMPTY;
    end
    if (cmd.pct_take) begin
      pct_r <= div_quot[PCT_W-1:0];
    end
    if (cmd.out_load) begin
      out_sample_mv_r      <= last_r;
      out_sample_stored_r  <= good_r;
      out_average_mv_r     <= avg_r;
      out_charge_percent_r <= pct_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < RING_DEPTH; i++) begin
        ring_r[i] <= '0;
      end
      idx_r   <= '0;
      last_r  <= '0;
      total_r <= '0;
    end else if (cmd.update) begin
      last_r <= new_last_c;
      if (purge_r) begin
        for (int i = 0; i < RING_DEPTH; i++) begin
          ring_r[i] <= new_last_c;
        end
        idx_r   <= '0;
        total_r <= TOTAL_W'(new_last_c) << RING_AW;
      end else if (good_r) begin
        ring_r[idx_r] <= limited_c;
        idx_r         <= (idx_r == RING_AW'(RING_DEPTH - 1)) ? '0 : idx_r + 1'b1;
        total_r       <= total_r - TOTAL_W'(ring_r[idx_r]) + TOTAL_W'(limited_c);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_sample_mv      = out_sample_mv_r;
  assign out_sample_stored  = out_sample_stored_r;
  assign out_average_mv     = out_average_mv_r;
  assign out_charge_percent = out_charge_percent_r;

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> (!out_valid_r || out_ready))
    else $error("result register loaded while a result was still waiting");

  a_pct_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> out_charge_percent_r <= PCT_FULL)
    else $error("charge percentage above one hundred");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_ready) |=> (out_valid_r && $stable(out_average_mv_r) &&
                                     $stable(out_charge_percent_r)))
    else $error("waiting result changed before its transfer");

endmodule

`default_nettype wire

// ===== rtl/core/battery_voltage_averager.sv =====
// Top level of the battery voltage averager: configuration, controller and datapath.
// Depends on bva_pkg, bva_cfg, bva_ctrl and bva_dp.
//
//   Channel  Ports                                     Moves
//   in       in_valid/in_ready + five field ports      one battery measurement
//   out      out_valid/out_ready + four field ports    sample, mean and percentage
//   cfg      cfg_valid/cfg_ready, cfg_index, cfg_data  one register write
//
// After its transfer, an item passes through the multiply steps, then the
// one-bit-per-cycle divider for the millivolt conversion and then for the
// percentage, which share that divider.
// A new item is taken as soon as the previous result sits in the output register.
// Reset clears the ring, the index, the last sample and sets the configuration registers to defaults.
// A stalled output holds the finished result and the next item waits in the last step.
`timescale 1ns / 1ps
`default_nettype none

module battery_voltage_averager
  import bva_pkg::*;
(
  input  wire                  clk,
  input  wire                  rst_n,
  input  wire                  in_valid,
  output logic                 in_ready,
  input  wire [SAMPLE_W-1:0]   in_battery_code,
  input  wire [SAMPLE_W-1:0]   in_supply_mv,
  input  wire                  in_conversion_good,
  input  wire                  in_limit_drop,
  input  wire                  in_purge_ring,
  output logic                 out_valid,
  input  wire                  out_ready,
  output logic [SAMPLE_W-1:0]  out_sample_mv,
  output logic                 out_sample_stored,
  output logic [SAMPLE_W-1:0]  out_average_mv,
  output logic [PCT_W-1:0]     out_charge_percent,
  input  wire                  cfg_valid,
  output logic                 cfg_ready,
  input  wire [CFG_IDX_W-1:0]  cfg_index,
  input  wire [SAMPLE_W-1:0]   cfg_data
);

  cfg_t     cfg;
  dp_cmd_t  cmd;
  dp_stat_t st;

  bva_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  bva_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .st       (st),
    .cmd      (cmd)
  );

  bva_dp u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .cmd                (cmd),
    .st                 (st),
    .cfg                (cfg),
    .in_battery_code    (in_battery_code),
    .in_supply_mv       (in_supply_mv),
    .in_conversion_good (in_conversion_good),
    .in_limit_drop      (in_limit_drop),
    .in_purge_ring      (in_purge_ring),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_sample_mv      (out_sample_mv),
    .out_sample_stored  (out_sample_stored),
    .out_average_mv     (out_average_mv),
    .out_charge_percent (out_charge_percent)
  );

endmodule

`default_nettype wire
